// ----- sv/assert_macros.svh -----
// Assertion helpers, clocked on clk with reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define CSFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define CSFS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CSFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/csfs_pkg.sv -----
`default_nettype none

package csfs_pkg;

    localparam int SAMPLES_PER_CHANNEL = 5;
    localparam int NUM_CHANNELS        = 4;

    localparam int PERIOD_W  = 16;
    localparam int ELAPSED_W = 16;
    localparam int US_W      = 20;
    localparam int HZ_W      = 27;
    localparam int CFG_IDX_W = 2;

    localparam int CNT_W = $clog2(SAMPLES_PER_CHANNEL + 1);
    localparam int IDX_W = $clog2(SAMPLES_PER_CHANNEL);
    localparam int SUM_W = PERIOD_W + $clog2(SAMPLES_PER_CHANNEL);

    localparam int TIMER_W = US_W + 1;

    localparam int DIV_DVW   = 28;
    localparam int DIV_DSW   = PERIOD_W;
    localparam int DIV_ITERS = DIV_DVW / 2;
    localparam int DIV_CNT_W = $clog2(DIV_ITERS + 1);

    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_CAPTURE = 2'd1;
    localparam logic [1:0] KIND_START   = 2'd2;
    localparam logic [1:0] KIND_CANCEL  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK   = 2'd2;

    localparam logic [US_W-1:0] SETTLE_RESET  = 20'd10000;
    localparam logic [US_W-1:0] TIMEOUT_RESET = 20'd100000;
    localparam logic [HZ_W-1:0] CLOCK_RESET   = 27'd6000000;

    // bit1 drives S2, bit0 drives S3
    localparam logic [1:0] FILTER_CLEAR = 2'h2;
    localparam logic [1:0] FILTER_RED   = 2'h0;
    localparam logic [1:0] FILTER_GREEN = 2'h3;
    localparam logic [1:0] FILTER_BLUE  = 2'h1;

    function automatic logic [1:0] chan_filter(input logic [1:0] ch);
        logic [1:0] f;
        case (ch)
            2'd0:    f = FILTER_CLEAR;
            2'd1:    f = FILTER_RED;
            2'd2:    f = FILTER_GREEN;
            default: f = FILTER_BLUE;
        endcase
        return f;
    endfunction

    typedef enum logic [3:0] {
        OP_NOP,
        OP_EMIT,
        OP_FETCH,
        OP_CLR,
        OP_TIMER_ADD,
        OP_SET_FILTER,
        OP_SETTLE_END,
        OP_DISC_TAKE,
        OP_STORE,
        OP_FIN_TO,
        OP_SUM_INIT,
        OP_SUM_STEP,
        OP_DIV_TRIM,
        OP_DIV_CLK,
        OP_FIN_QUO,
        OP_FIN_ZERO
    } op_t;

    typedef enum logic [4:0] {
        C_NEVER,
        C_ALWAYS,
        C_OUT_BUSY,
        C_NO_ITEM,
        C_KIND_CAP,
        C_KIND_START,
        C_KIND_CANCEL,
        C_RUNNING,
        C_NOT_RUNNING,
        C_PH_SETF,
        C_PH_SETTLE,
        C_PH_DISC,
        C_PH_SAMPLE,
        C_PH_COMP,
        C_SETTLE_WAIT,
        C_TIMEOUT,
        C_NO_PENDING,
        C_SUM_MORE,
        C_DIV_BUSY,
        C_AVG_ZERO,
        C_CAPTURE
    } cond_t;

    localparam int PC_W = 6;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    localparam logic [PC_W-1:0] L_EMIT     = PC_W'(0);
    localparam logic [PC_W-1:0] L_FETCH    = PC_W'(1);
    localparam logic [PC_W-1:0] L_DISPATCH = PC_W'(2);
    localparam logic [PC_W-1:0] L_TICK     = PC_W'(5);
    localparam logic [PC_W-1:0] L_SETF     = PC_W'(12);
    localparam logic [PC_W-1:0] L_SETTLE   = PC_W'(13);
    localparam logic [PC_W-1:0] L_DISC     = PC_W'(15);
    localparam logic [PC_W-1:0] L_SAMPLE   = PC_W'(18);
    localparam logic [PC_W-1:0] L_TO       = PC_W'(21);
    localparam logic [PC_W-1:0] L_COMP     = PC_W'(22);
    localparam logic [PC_W-1:0] L_SUM      = PC_W'(23);
    localparam logic [PC_W-1:0] L_DIV1     = PC_W'(24);
    localparam logic [PC_W-1:0] L_DIV2     = PC_W'(27);
    localparam logic [PC_W-1:0] L_FZERO    = PC_W'(30);
    localparam logic [PC_W-1:0] L_CAP      = PC_W'(31);
    localparam logic [PC_W-1:0] L_START    = PC_W'(32);
    localparam logic [PC_W-1:0] L_CANCEL   = PC_W'(34);

    // Jump taken when cond holds, else fall through to pc + 1.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t u;
        case (pc)
            L_EMIT:                  u = '{OP_EMIT,       C_OUT_BUSY,    L_EMIT};
            L_FETCH:                 u = '{OP_FETCH,      C_NO_ITEM,     L_FETCH};
            L_DISPATCH:              u = '{OP_CLR,        C_KIND_CAP,    L_CAP};
            L_DISPATCH + PC_W'(1):   u = '{OP_NOP,        C_KIND_START,  L_START};
            L_DISPATCH + PC_W'(2):   u = '{OP_NOP,        C_KIND_CANCEL, L_CANCEL};
            L_TICK:                  u = '{OP_NOP,        C_NOT_RUNNING, L_EMIT};
            L_TICK + PC_W'(1):       u = '{OP_TIMER_ADD,  C_PH_SETF,     L_SETF};
            L_TICK + PC_W'(2):       u = '{OP_NOP,        C_PH_SETTLE,   L_SETTLE};
            L_TICK + PC_W'(3):       u = '{OP_NOP,        C_PH_DISC,     L_DISC};
            L_TICK + PC_W'(4):       u = '{OP_NOP,        C_PH_SAMPLE,   L_SAMPLE};
            L_TICK + PC_W'(5):       u = '{OP_NOP,        C_PH_COMP,     L_COMP};
            L_TICK + PC_W'(6):       u = '{OP_NOP,        C_ALWAYS,      L_EMIT};
            L_SETF:                  u = '{OP_SET_FILTER, C_ALWAYS,      L_EMIT};
            L_SETTLE:                u = '{OP_NOP,        C_SETTLE_WAIT, L_EMIT};
            L_SETTLE + PC_W'(1):     u = '{OP_SETTLE_END, C_ALWAYS,      L_EMIT};
            L_DISC:                  u = '{OP_NOP,        C_TIMEOUT,     L_TO};
            L_DISC + PC_W'(1):       u = '{OP_NOP,        C_NO_PENDING,  L_EMIT};
            L_DISC + PC_W'(2):       u = '{OP_DISC_TAKE,  C_ALWAYS,      L_EMIT};
            L_SAMPLE:                u = '{OP_NOP,        C_TIMEOUT,     L_TO};
            L_SAMPLE + PC_W'(1):     u = '{OP_NOP,        C_NO_PENDING,  L_EMIT};
            L_SAMPLE + PC_W'(2):     u = '{OP_STORE,      C_ALWAYS,      L_EMIT};
            L_TO:                    u = '{OP_FIN_TO,     C_ALWAYS,      L_EMIT};
            L_COMP:                  u = '{OP_SUM_INIT,   C_NEVER,       L_EMIT};
            L_SUM:                   u = '{OP_SUM_STEP,   C_SUM_MORE,    L_SUM};
            L_DIV1:                  u = '{OP_DIV_TRIM,   C_NEVER,       L_EMIT};
            L_DIV1 + PC_W'(1):       u = '{OP_NOP,        C_DIV_BUSY,    L_DIV1 + PC_W'(1)};
            L_DIV1 + PC_W'(2):       u = '{OP_NOP,        C_AVG_ZERO,    L_FZERO};
            L_DIV2:                  u = '{OP_DIV_CLK,    C_NEVER,       L_EMIT};
            L_DIV2 + PC_W'(1):       u = '{OP_NOP,        C_DIV_BUSY,    L_DIV2 + PC_W'(1)};
            L_DIV2 + PC_W'(2):       u = '{OP_FIN_QUO,    C_ALWAYS,      L_EMIT};
            L_FZERO:                 u = '{OP_FIN_ZERO,   C_ALWAYS,      L_EMIT};
            L_CAP:                   u = '{OP_NOP,        C_CAPTURE,     L_EMIT};
            L_START:                 u = '{OP_NOP,        C_RUNNING,     L_EMIT};
            L_START + PC_W'(1):      u = '{OP_NOP,        C_ALWAYS,      L_EMIT};
            L_CANCEL:                u = '{OP_NOP,        C_NOT_RUNNING, L_EMIT};
            L_CANCEL + PC_W'(1):     u = '{OP_NOP,        C_ALWAYS,      L_EMIT};
            default:                 u = '{OP_NOP,        C_ALWAYS,      L_FETCH};
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// ----- sv/csfs_div.sv -----
`default_nettype none

module csfs_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [csfs_pkg::DIV_DVW-1:0] dividend,
    input  wire logic [csfs_pkg::DIV_DSW-1:0] divisor,
    output logic                              busy,
    output logic [csfs_pkg::DIV_DVW-1:0]      quotient
);
    import csfs_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_DSW:0]     rem_reg;
    logic [DIV_DVW-1:0]   quo_reg;
    logic [DIV_DSW-1:0]   dsr_reg;
    logic [DIV_DSW:0]     rem_next;
    logic [DIV_DVW-1:0]   quo_next;

    // two restoring steps per cycle
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int k = 0; k < 2; k++)
        begin
            rem_next = {rem_next[DIV_DSW-1:0], quo_next[DIV_DVW-1]};
            quo_next = {quo_next[DIV_DVW-2:0], 1'b0};
            if (rem_next >= {1'b0, dsr_reg})
            begin
                rem_next    = rem_next - {1'b0, dsr_reg};
                quo_next[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= DIV_CNT_W'(DIV_ITERS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- sv/color_sensor_frequency_sequencer.sv -----
// Color sensor frequency sequencer.
// Input channel (in_valid / in_stall): one beat per item with kind, elapsed_us
// and capture_period. Kind selects tick, capture, start run or cancel run.
// Output channel (out_valid / out_stall): exactly one result beat per item,
// carrying filter pins, busy, channel result and run status.
// Configuration: cfg_we writes cfg_wdata into register cfg_index
// (0 settle_us, 1 timeout_us, 2 timer_clock_hz) at the clock edge.
// Items are handled one at a time by a microcoded step sequencer; the input
// is taken only while the sequencer sits in its fetch step.
// The tick that computes a channel frequency runs the serial sample sum and then
// two passes of the 2-bit-per-cycle divider.
// A finished result sits in the output register; the next item is accepted
// and processed meanwhile, and the sequencer waits for the output only when it
// must hand over a new result while the previous beat is still stalled.
// Reset: idle, no run, filter pins on the clear filter, registers at their
// default values, output register empty.
`default_nettype none

module color_sensor_frequency_sequencer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [csfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [csfs_pkg::HZ_W-1:0]      cfg_wdata,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [1:0]                     kind,
    input  wire logic [csfs_pkg::ELAPSED_W-1:0] elapsed_us,
    input  wire logic [csfs_pkg::PERIOD_W-1:0]  capture_period,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [1:0]                          filter_select,
    output logic                                busy_res,
    output logic                                channel_done,
    output logic [1:0]                          channel_index,
    output logic [csfs_pkg::HZ_W-1:0]           frequency_hz,
    output logic                                channel_timed_out,
    output logic                                run_done,
    output logic                                run_ok
);
    import csfs_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SET_FILTER,
        PH_SETTLE,
        PH_DISCARD,
        PH_SAMPLE,
        PH_COMPUTE
    } phase_t;

    logic [PC_W-1:0]      pc_reg;
    logic [PC_W-1:0]      pc_next;
    ucode_t               u;
    logic                 cond_true;

    logic [US_W-1:0]      settle_reg;
    logic [US_W-1:0]      timeout_reg;
    logic [HZ_W-1:0]      clk_hz_reg;

    logic [1:0]           kind_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [PERIOD_W-1:0]  period_reg;

    phase_t               phase_reg;
    logic [1:0]           chan_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [TIMER_W-1:0]   timer_reg;
    logic                 pending_reg;
    logic [PERIOD_W-1:0]  latched_reg;
    logic                 running_reg;
    logic [1:0]           filter_reg;
    logic [PERIOD_W-1:0]  store_reg [SAMPLES_PER_CHANNEL];

    logic [IDX_W-1:0]     idx_reg;
    logic [SUM_W-1:0]     acc_reg;
    logic [PERIOD_W-1:0]  lo_reg;
    logic [PERIOD_W-1:0]  hi_reg;

    logic                 res_done_reg;
    logic [1:0]           res_index_reg;
    logic [HZ_W-1:0]      res_freq_reg;
    logic                 res_to_reg;
    logic                 res_run_done_reg;
    logic                 res_run_ok_reg;

    logic                 out_valid_reg;
    logic [1:0]           out_filter_reg;
    logic                 out_busy_reg;
    logic                 out_done_reg;
    logic [1:0]           out_index_reg;
    logic [HZ_W-1:0]      out_freq_reg;
    logic                 out_to_reg;
    logic                 out_run_done_reg;
    logic                 out_run_ok_reg;

    logic                 in_accept;
    logic                 out_blocked;
    logic [TIMER_W:0]     timer_sum;
    logic [CNT_W-1:0]     count_inc;
    logic [PERIOD_W-1:0]  sample_rd;
    logic [SUM_W-1:0]     trimmed;
    logic                 fin;
    logic [HZ_W-1:0]      fin_freq;

    logic                 div_start;
    logic [DIV_DVW-1:0]   div_dividend;
    logic [DIV_DSW-1:0]   div_divisor;
    logic                 div_busy;
    logic [DIV_DVW-1:0]   div_quotient;

    assign u           = ucode_rom(pc_reg);
    assign in_stall    = (pc_reg != L_FETCH);
    assign in_accept   = in_valid && !in_stall;
    assign out_blocked = out_valid_reg && out_stall;
    assign timer_sum   = {1'b0, timer_reg} + (TIMER_W + 1)'(elapsed_reg);
    assign count_inc   = count_reg + CNT_W'(1);
    assign sample_rd   = store_reg[idx_reg];
    assign trimmed     = acc_reg - SUM_W'(lo_reg) - SUM_W'(hi_reg);

    always_comb
    begin
        case (u.cond)
            C_NEVER:       cond_true = 1'b0;
            C_ALWAYS:      cond_true = 1'b1;
            C_OUT_BUSY:    cond_true = out_blocked;
            C_NO_ITEM:     cond_true = !in_valid;
            C_KIND_CAP:    cond_true = (kind_reg == KIND_CAPTURE);
            C_KIND_START:  cond_true = (kind_reg == KIND_START);
            C_KIND_CANCEL: cond_true = (kind_reg == KIND_CANCEL);
            C_RUNNING:     cond_true = running_reg;
            C_NOT_RUNNING: cond_true = !running_reg;
            C_PH_SETF:     cond_true = (phase_reg == PH_SET_FILTER);
            C_PH_SETTLE:   cond_true = (phase_reg == PH_SETTLE);
            C_PH_DISC:     cond_true = (phase_reg == PH_DISCARD);
            C_PH_SAMPLE:   cond_true = (phase_reg == PH_SAMPLE);
            C_PH_COMP:     cond_true = (phase_reg == PH_COMPUTE);
            C_SETTLE_WAIT: cond_true = (timer_reg < TIMER_W'(settle_reg));
            C_TIMEOUT:     cond_true = (timer_reg > TIMER_W'(timeout_reg));
            C_NO_PENDING:  cond_true = !pending_reg;
            C_SUM_MORE:    cond_true = (idx_reg != IDX_W'(SAMPLES_PER_CHANNEL - 1));
            C_DIV_BUSY:    cond_true = div_busy;
            C_AVG_ZERO:    cond_true = (div_quotient[DIV_DSW-1:0] == '0);
            C_CAPTURE:     cond_true = 1'b1;
            default:       cond_true = 1'b1;
        endcase
    end

    assign pc_next = cond_true ? u.target : pc_reg + PC_W'(1);

    assign div_start    = (u.op == OP_DIV_TRIM) || (u.op == OP_DIV_CLK);
    assign div_dividend = (u.op == OP_DIV_TRIM) ? DIV_DVW'(trimmed) : DIV_DVW'(clk_hz_reg);
    assign div_divisor  = (u.op == OP_DIV_TRIM) ? DIV_DSW'(SAMPLES_PER_CHANNEL - 2)
                                                : div_quotient[DIV_DSW-1:0];

    assign fin = (u.op == OP_FIN_TO) || (u.op == OP_FIN_QUO) || (u.op == OP_FIN_ZERO);
    assign fin_freq = (u.op == OP_FIN_QUO) ? div_quotient[HZ_W-1:0] : '0;

    csfs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk)
    begin
        if (u.op == OP_STORE && count_reg < CNT_W'(SAMPLES_PER_CHANNEL))
        begin
            store_reg[count_reg[IDX_W-1:0]] <= latched_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg           <= L_FETCH;
            settle_reg       <= SETTLE_RESET;
            timeout_reg      <= TIMEOUT_RESET;
            clk_hz_reg       <= CLOCK_RESET;
            kind_reg         <= KIND_TICK;
            elapsed_reg      <= '0;
            period_reg       <= '0;
            phase_reg        <= PH_IDLE;
            chan_reg         <= '0;
            count_reg        <= '0;
            timer_reg        <= '0;
            pending_reg      <= 1'b0;
            latched_reg      <= '0;
            running_reg      <= 1'b0;
            filter_reg       <= FILTER_CLEAR;
            idx_reg          <= '0;
            acc_reg          <= '0;
            lo_reg           <= '0;
            hi_reg           <= '0;
            res_done_reg     <= 1'b0;
            res_index_reg    <= '0;
            res_freq_reg     <= '0;
            res_to_reg       <= 1'b0;
            res_run_done_reg <= 1'b0;
            res_run_ok_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_filter_reg   <= FILTER_CLEAR;
            out_busy_reg     <= 1'b0;
            out_done_reg     <= 1'b0;
            out_index_reg    <= '0;
            out_freq_reg     <= '0;
            out_to_reg       <= 1'b0;
            out_run_done_reg <= 1'b0;
            out_run_ok_reg   <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SETTLE:  settle_reg  <= cfg_wdata[US_W-1:0];
                    CFG_TIMEOUT: timeout_reg <= cfg_wdata[US_W-1:0];
                    CFG_CLOCK:   clk_hz_reg  <= cfg_wdata;
                    default:     ;
                endcase
            end

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (u.op)
                OP_EMIT:
                begin
                    if (!out_blocked)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_filter_reg   <= filter_reg;
                        out_busy_reg     <= running_reg;
                        out_done_reg     <= res_done_reg;
                        out_index_reg    <= res_index_reg;
                        out_freq_reg     <= res_freq_reg;
                        out_to_reg       <= res_to_reg;
                        out_run_done_reg <= res_run_done_reg;
                        out_run_ok_reg   <= res_run_ok_reg;
                    end
                end
                OP_FETCH:
                begin
                    if (in_accept)
                    begin
                        kind_reg    <= kind;
                        elapsed_reg <= elapsed_us;
                        period_reg  <= capture_period;
                    end
                end
                OP_CLR:
                begin
                    res_done_reg     <= 1'b0;
                    res_index_reg    <= '0;
                    res_freq_reg     <= '0;
                    res_to_reg       <= 1'b0;
                    res_run_done_reg <= 1'b0;
                    res_run_ok_reg   <= 1'b0;
                end
                OP_TIMER_ADD:
                begin
                    timer_reg <= timer_sum[TIMER_W] ? '1 : timer_sum[TIMER_W-1:0];
                end
                OP_SET_FILTER:
                begin
                    filter_reg <= chan_filter(chan_reg);
                    phase_reg  <= PH_SETTLE;
                    timer_reg  <= '0;
                end
                OP_SETTLE_END:
                begin
                    pending_reg <= 1'b0;
                    phase_reg   <= PH_DISCARD;
                    timer_reg   <= '0;
                end
                OP_DISC_TAKE:
                begin
                    pending_reg <= 1'b0;
                    count_reg   <= '0;
                    phase_reg   <= PH_SAMPLE;
                    timer_reg   <= '0;
                end
                OP_STORE:
                begin
                    pending_reg <= 1'b0;
                    count_reg   <= count_inc;
                    if (count_inc >= CNT_W'(SAMPLES_PER_CHANNEL))
                    begin
                        phase_reg <= PH_COMPUTE;
                    end
                end
                OP_SUM_INIT:
                begin
                    idx_reg <= '0;
                    acc_reg <= '0;
                    lo_reg  <= '1;
                    hi_reg  <= '0;
                end
                OP_SUM_STEP:
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    acc_reg <= acc_reg + SUM_W'(sample_rd);
                    if (sample_rd < lo_reg)
                    begin
                        lo_reg <= sample_rd;
                    end
                    if (sample_rd > hi_reg)
                    begin
                        hi_reg <= sample_rd;
                    end
                end
                default:
                begin
                end
            endcase

            if (fin)
            begin
                res_done_reg  <= 1'b1;
                res_index_reg <= chan_reg;
                res_freq_reg  <= fin_freq;
                res_to_reg    <= (u.op == OP_FIN_TO);
                count_reg     <= '0;
                if (chan_reg == 2'(NUM_CHANNELS - 1))
                begin
                    chan_reg         <= '0;
                    running_reg      <= 1'b0;
                    phase_reg        <= PH_IDLE;
                    res_run_done_reg <= 1'b1;
                    res_run_ok_reg   <= 1'b1;
                end
                else
                begin
                    chan_reg  <= chan_reg + 2'd1;
                    phase_reg <= PH_SET_FILTER;
                end
            end

            // capture item
            if (pc_reg == L_CAP)
            begin
                latched_reg <= period_reg;
                if (running_reg)
                begin
                    pending_reg <= 1'b1;
                end
            end

            // start item while idle
            if (pc_reg == L_START + PC_W'(1))
            begin
                chan_reg    <= '0;
                count_reg   <= '0;
                timer_reg   <= '0;
                pending_reg <= 1'b0;
                phase_reg   <= PH_SET_FILTER;
                running_reg <= 1'b1;
            end

            // cancel item while busy
            if (pc_reg == L_CANCEL + PC_W'(1))
            begin
                running_reg      <= 1'b0;
                phase_reg        <= PH_IDLE;
                pending_reg      <= 1'b0;
                res_run_done_reg <= 1'b1;
                res_run_ok_reg   <= 1'b0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign filter_select     = out_filter_reg;
    assign busy_res          = out_busy_reg;
    assign channel_done      = out_done_reg;
    assign channel_index     = out_index_reg;
    assign frequency_hz      = out_freq_reg;
    assign channel_timed_out = out_to_reg;
    assign run_done          = out_run_done_reg;
    assign run_ok            = out_run_ok_reg;

endmodule

`default_nettype wire

// ----- sv/csfs_chk.sv -----
`default_nettype none
`include "assert_macros.svh"

module csfs_chk (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           cfg_we,
    input wire logic [csfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input wire logic [csfs_pkg::HZ_W-1:0]      cfg_wdata,
    input wire logic                           in_valid,
    input wire logic                           in_stall,
    input wire logic [1:0]                     kind,
    input wire logic [csfs_pkg::ELAPSED_W-1:0] elapsed_us,
    input wire logic [csfs_pkg::PERIOD_W-1:0]  capture_period,
    input wire logic                           out_valid,
    input wire logic                           out_stall,
    input wire logic [1:0]                     filter_select,
    input wire logic                           busy_res,
    input wire logic                           channel_done,
    input wire logic [1:0]                     channel_index,
    input wire logic [csfs_pkg::HZ_W-1:0]      frequency_hz,
    input wire logic                           channel_timed_out,
    input wire logic                           run_done,
    input wire logic                           run_ok
);
    import csfs_pkg::*;

    logic unused_ok;
    assign unused_ok = cfg_we ^ (|cfg_index) ^ (|cfg_wdata) ^ in_valid ^ in_stall
                     ^ (|kind) ^ (|elapsed_us) ^ (|capture_period) ^ (|filter_select);

    `CSFS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(frequency_hz) && $stable(run_done), "stalled result beat changed")
    `CSFS_ASSERT_IMPLY(a_ok_needs_done, out_valid && run_ok, run_done && channel_done,
        "run_ok without a finished last channel")
    `CSFS_ASSERT_IMPLY(a_freq_valid, out_valid && frequency_hz != '0,
        channel_done && !channel_timed_out, "frequency reported without a measured channel")
    `CSFS_ASSERT_IMPLY(a_done_idle, out_valid && run_done, !busy_res,
        "run ended but block still busy")
    `CSFS_ASSERT_IMPLY(a_no_chan, out_valid && !channel_done,
        channel_index == 2'd0 && !channel_timed_out, "channel fields set without a channel")

endmodule

bind color_sensor_frequency_sequencer csfs_chk u_csfs_chk (.*);

`default_nettype wire
